[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

[sv/dfs_pkg.sv]
package dfs_pkg;

    localparam int BYTE_W     = 8;
    localparam int MASK_W     = 64;
    localparam int MASK_IDX_W = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_IN_DELIM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DELIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_MASK = 2'd2;

    localparam logic [BYTE_W-1:0] IN_DELIM_RST   = 8'd9;
    localparam logic [BYTE_W-1:0] OUT_DELIM_RST  = 8'd9;
    localparam logic [MASK_W-1:0] FIELD_MASK_RST = 64'd1;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELIM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } dfs_entry_t;

endpackage

[sv/dfs_front.sv]
`include "assert_macros.svh"

module dfs_front
    import dfs_pkg::*;
#(
    parameter int MAX_FIELDS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [BYTE_W-1:0] in_delim,
    input  logic [MASK_W-1:0] field_mask,
    output logic              emit,
    output dfs_entry_t        entry
);

    localparam int IDX_W = $clog2(MAX_FIELDS + 2);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_FIELDS);
    localparam logic [IDX_W-1:0] IDX_SAT  = IDX_W'(MAX_FIELDS + 1);

    logic [IDX_W-1:0] fi_reg;
    logic [IDX_W-1:0] fi_next;
    logic             seen_reg;
    logic             seen_next;

    logic             is_nl;
    logic             is_delim;
    logic [IDX_W-1:0] fi_adv;
    logic             sel_cur;
    logic             sel_adv;
    logic             seen_new;

    assign is_nl    = (in_byte == NEWLINE_BYTE);
    assign is_delim = !is_nl && (in_byte == in_delim);
    assign fi_adv   = (fi_reg < IDX_SAT) ? fi_reg + IDX_ONE : fi_reg;
    assign sel_cur  = (fi_reg <= IDX_LAST) && field_mask[MASK_IDX_W'(fi_reg - IDX_ONE)];
    assign sel_adv  = (fi_adv <= IDX_LAST) && field_mask[MASK_IDX_W'(fi_adv - IDX_ONE)];
    assign seen_new = seen_reg || sel_cur;

    always_comb
    begin
        fi_next    = fi_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        entry.data = in_byte;
        entry.kind = KIND_DATA;
        if (accept)
        begin
            if (is_nl)
            begin
                fi_next    = IDX_ONE;
                seen_next  = 1'b0;
                emit       = 1'b1;
                entry.kind = KIND_NEWLINE;
            end
            else if (is_delim)
            begin
                fi_next    = fi_adv;
                seen_next  = seen_new;
                emit       = seen_new && sel_adv;
                entry.kind = KIND_DELIM;
            end
            else
            begin
                emit = sel_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg   <= IDX_ONE;
            seen_reg <= 1'b0;
        end
        else
        begin
            fi_reg   <= fi_next;
            seen_reg <= seen_next;
        end
    end

    `ASSERT_ALWAYS(a_fi_range, (fi_reg >= IDX_ONE) && (fi_reg <= IDX_SAT), "field index out of range")
    `ASSERT_NEXT(a_nl_restart, accept && is_nl, (fi_reg == IDX_ONE) && !seen_reg, "newline did not restart line")

endmodule

[sv/dfs_queue.sv]
`include "assert_macros.svh"

module dfs_queue
    import dfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  dfs_entry_t wr_entry,
    input  logic       rd_en,
    output dfs_entry_t rd_entry,
    output logic       full,
    output logic       not_empty
);

    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QCNT_W-1:0] CNT_ONE  = QCNT_W'(1);
    localparam logic [QPTR_W-1:0] PTR_ONE  = QPTR_W'(1);

    dfs_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign rd_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(wr_en && full), "write into full queue")
    `ASSERT_ALWAYS(a_no_underflow, !(rd_en && !not_empty), "read from empty queue")
    `ASSERT_ALWAYS(a_cnt_ptrs, QPTR_W'(cnt_reg) == QPTR_W'(wr_ptr_reg - rd_ptr_reg), "count and pointers disagree")

endmodule

[sv/dfs_back.sv]
`include "assert_macros.svh"

module dfs_back
    import dfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  dfs_entry_t        q_entry,
    output logic              q_rd,
    input  logic [BYTE_W-1:0] out_delim,
    input  logic              pop,
    output logic              empty,
    output logic [BYTE_W-1:0] out_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              xfer;

    assign xfer  = pop && valid_reg;
    assign q_rd  = q_not_empty && (!valid_reg || xfer);
    assign empty = !valid_reg;
    assign out_byte = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (q_rd)
        begin
            valid_next = 1'b1;
            case (q_entry.kind)
                KIND_NEWLINE: byte_next = NEWLINE_BYTE;
                KIND_DELIM:   byte_next = out_delim;
                KIND_DATA:    byte_next = q_entry.data;
                default:      byte_next = q_entry.data;
            endcase
        end
        else if (xfer)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    `ASSERT_NEXT(a_load_valid, q_rd, valid_reg, "loaded result not presented")
    `ASSERT_ALWAYS(a_q_rd_room, !(q_rd && valid_reg && !pop), "queue read with output occupied")

endmodule

[sv/delimited_field_selector_core.sv]
// A selected byte accepted on the input is written into the queue, then loaded into the output register on out_byte.
// Throughput: one byte per cycle while the queue is not full; the field counter and mask test are combinational.
// A four-entry queue and one output register let input and output stall independently.
// Reset (rst_n low, async): queue and output empty, field 1, in/out delimiter 9, mask 1.
module delimited_field_selector_core
    import dfs_pkg::*;
#(
    parameter int MAX_FIELDS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    in_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [BYTE_W-1:0]    out_byte
);

    logic [BYTE_W-1:0] in_delim_reg;
    logic [BYTE_W-1:0] out_delim_reg;
    logic [MASK_W-1:0] field_mask_reg;

    logic       accept;
    logic       emit;
    dfs_entry_t f_entry;
    dfs_entry_t q_entry;
    logic       q_rd;
    logic       q_full;
    logic       q_not_empty;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_delim_reg   <= IN_DELIM_RST;
            out_delim_reg  <= OUT_DELIM_RST;
            field_mask_reg <= FIELD_MASK_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IN_DELIM:   in_delim_reg   <= cfg_data[BYTE_W-1:0];
                REG_OUT_DELIM:  out_delim_reg  <= cfg_data[BYTE_W-1:0];
                REG_FIELD_MASK: field_mask_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    dfs_front #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .in_delim   (in_delim_reg),
        .field_mask (field_mask_reg),
        .emit       (emit),
        .entry      (f_entry)
    );

    dfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (emit),
        .wr_entry  (f_entry),
        .rd_en     (q_rd),
        .rd_entry  (q_entry),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    dfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_entry     (q_entry),
        .q_rd        (q_rd),
        .out_delim   (out_delim_reg),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte)
    );

endmodule

[sim/delimited_field_selector_core_tb.sv]
`timescale 1ns / 100ps

module delimited_field_selector_core_tb
    import dfs_pkg::*;
();

    localparam int MAX_FIELDS   = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 450;
    localparam int SETTLE       = 10;
    localparam int DIR_ROWS     = 38;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_BYTE} out_chk_t;
    typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        out_chk_t          chk;
        logic [BYTE_W-1:0] res;
    } tx_item_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [MASK_W-1:0]    data;
        out_chk_t             chk;
        logic [BYTE_W-1:0]    res;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MASK_W-1:0]    cfg_data  = '0;
    logic                 push      = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    in_byte   = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    logic [BYTE_W-1:0]    out_byte;

    // predictor state and register copies
    logic [6:0]        cut_field     = 7'd1;
    logic              cut_seen      = 1'b0;
    logic [BYTE_W-1:0] cut_in_delim  = IN_DELIM_RST;
    logic [BYTE_W-1:0] cut_out_delim = OUT_DELIM_RST;
    logic [MASK_W-1:0] cut_mask      = FIELD_MASK_RST;

    tx_item_t          send_q[$];
    logic [BYTE_W-1:0] expected_bytes[$];
    dir_row_t          dir_rows[DIR_ROWS];

    int   errors      = 0;
    int   cycle_count = 0;
    int   rand_items  = 0;
    int   burst_left  = 0;
    int   gap_left    = 0;
    int   hold_left   = 0;
    int   pat_left    = 0;
    logic [15:0] pop_pat = '0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    delimited_field_selector_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic field_on(input logic [6:0] k);
        if (k < 1 || k > MAX_FIELDS)
        begin
            return 1'b0;
        end
        return cut_mask[k - 1];
    endfunction

    // returns 1 when the byte produces an output transfer
    function automatic logic cut_step(input logic [BYTE_W-1:0] b,
                                      output logic [BYTE_W-1:0] r);
        logic seen;
        r = b;
        if (b == NEWLINE_BYTE)
        begin
            cut_field = 7'd1;
            cut_seen  = 1'b0;
            return 1'b1;
        end
        if (b == cut_in_delim)
        begin
            seen = cut_seen || field_on(cut_field);
            if (cut_field < MAX_FIELDS + 1)
            begin
                cut_field++;
            end
            cut_seen = seen;
            r = cut_out_delim;
            return seen && field_on(cut_field);
        end
        return field_on(cut_field);
    endfunction

    function automatic void note_error(input string what, input logic [BYTE_W-1:0] want,
                                       input logic [BYTE_W-1:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected %02h, got %02h", $time, what, want, got);
        end
    endfunction

    function automatic void queue_byte(input logic [BYTE_W-1:0] v);
        send_q.push_back('{v, OUT_MODEL, 8'h00});
        rand_items++;
    endfunction

    task automatic queue_line(input logic long_line, input logic [BYTE_W-1:0] delim);
        int nfields;
        int len;
        logic [BYTE_W-1:0] v;
        nfields = long_line ? $urandom_range(62, 70) : $urandom_range(1, 8);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
            begin
                queue_byte(delim);
            end
            len = long_line ? $urandom_range(0, 1) : $urandom_range(0, 5);
            for (int j = 0; j < len; j++)
            begin
                do
                    v = 8'($urandom_range(0, 255));
                while (v == delim || v == NEWLINE_BYTE);
                queue_byte(v);
            end
        end
        queue_byte(NEWLINE_BYTE);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (send_q.size() != 0 || push || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // input side: bursts with random gaps; transfer feeds the predictor
    always @(posedge clk)
    begin : sender
        logic              nxt_push;
        tx_item_t          item;
        logic [BYTE_W-1:0] res;
        logic              has_res;
        if (rst_n)
        begin
            nxt_push = push;
            if (push && !full)
            begin
                item    = send_q.pop_front();
                has_res = cut_step(item.value, res);
                case (item.chk)
                    OUT_MODEL: if (has_res) expected_bytes.push_back(res);
                    OUT_BYTE:  expected_bytes.push_back(item.res);
                    default:   ;
                endcase
                nxt_push = 1'b0;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
            end
            if (!nxt_push)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (send_q.size() != 0)
                begin
                    nxt_push = 1'b1;
                    in_byte <= send_q[0].value;
                end
            end
            push <= nxt_push;
        end
    end

    // output side: stall pattern plus one long hold-off
    always @(posedge clk)
    begin : receiver
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (pat_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       pop_pat = '1;
                1:       pop_pat = 16'($urandom);
                2:       pop_pat = 16'($urandom | $urandom);
                default: pop_pat = 16'($urandom & $urandom);
            endcase
            pat_left = 16;
        end
        pop <= rst_n && hold_left == 0 && pop_pat[0];
        pop_pat = {pop_pat[0], pop_pat[15:1]};
        pat_left--;
        if (hold_left > 0)
        begin
            hold_left--;
        end
    end

    always @(posedge clk)
    begin : check_out
        logic [BYTE_W-1:0] want;
        if (rst_n && cfg_wr_en)
        begin
            case (cfg_index)
                REG_IN_DELIM:   cut_in_delim  = cfg_data[BYTE_W-1:0];
                REG_OUT_DELIM:  cut_out_delim = cfg_data[BYTE_W-1:0];
                REG_FIELD_MASK: cut_mask      = cfg_data;
                default:        ;
            endcase
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
            begin
                note_error("transfer with nothing expected", 'x, out_byte);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want)
                begin
                    note_error("out_byte mismatch", want, out_byte);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** delimited_field_selector_core: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                phase;
        int                phase_end;
        logic [BYTE_W-1:0] in_d;
        logic [BYTE_W-1:0] out_d;
        logic [MASK_W-1:0] mask;

        dir_rows = '{
            // reset settings: tab delimiter, field 1 only
            '{ROW_BYTE,  REG_IN_DELIM,   64'h41, OUT_BYTE,  8'h41},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h09, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h42, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h0A, OUT_BYTE,  8'h0A},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h00, OUT_BYTE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'hFF, OUT_BYTE,  8'hFF},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h0A, OUT_BYTE,  8'h0A},
            // all fields, empty fields still separated
            '{ROW_WRITE, REG_FIELD_MASK, '1,     OUT_MODEL, 8'h00},
            '{ROW_WRITE, REG_IN_DELIM,   64'h2C, OUT_MODEL, 8'h00},
            '{ROW_WRITE, REG_OUT_DELIM,  64'h3B, OUT_MODEL, 8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h2C, OUT_BYTE,  8'h3B},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h2C, OUT_BYTE,  8'h3B},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h78, OUT_BYTE,  8'h78},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h0A, OUT_BYTE,  8'h0A},
            // newline as delimiter stays a newline
            '{ROW_WRITE, REG_IN_DELIM,   64'h0A, OUT_MODEL, 8'h00},
            '{ROW_WRITE, REG_OUT_DELIM,  64'hFF, OUT_MODEL, 8'h00},
            '{ROW_WRITE, REG_FIELD_MASK, 64'h8000_0000_0000_0002, OUT_MODEL, 8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h61, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h0A, OUT_BYTE,  8'h0A},
            // empty mask
            '{ROW_WRITE, REG_FIELD_MASK, 64'h0,  OUT_MODEL, 8'h00},
            '{ROW_WRITE, REG_IN_DELIM,   64'h00, OUT_MODEL, 8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h71, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h00, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h0A, OUT_BYTE,  8'h0A},
            // fields 1 and 3, delimiter 0xFF, output delimiter 0x00
            '{ROW_WRITE, REG_IN_DELIM,   64'hFF, OUT_MODEL, 8'h00},
            '{ROW_WRITE, REG_OUT_DELIM,  64'h00, OUT_MODEL, 8'h00},
            '{ROW_WRITE, REG_FIELD_MASK, 64'h5,  OUT_MODEL, 8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h61, OUT_BYTE,  8'h61},
            '{ROW_BYTE,  REG_IN_DELIM,   64'hFF, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h62, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'hFF, OUT_BYTE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h63, OUT_BYTE,  8'h63},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h0A, OUT_BYTE,  8'h0A},
            // first selected field after a delimiter: no leading separator
            '{ROW_WRITE, REG_FIELD_MASK, 64'h6,  OUT_MODEL, 8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'hFF, OUT_NONE,  8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h62, OUT_MODEL, 8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'hFF, OUT_MODEL, 8'h00},
            '{ROW_BYTE,  REG_IN_DELIM,   64'h0A, OUT_MODEL, 8'h00}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                send_q.push_back('{dir_rows[i].data[BYTE_W-1:0], dir_rows[i].chk,
                                   dir_rows[i].res});
            end
        end

        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:       in_d = 8'h09;
                1:       in_d = 8'h00;
                2:       in_d = 8'hFF;
                3:       in_d = NEWLINE_BYTE;
                4:       in_d = 8'h2C;
                default: in_d = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       out_d = 8'h00;
                1:       out_d = 8'hFF;
                2:       out_d = NEWLINE_BYTE;
                default: out_d = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 6))
                0:       mask = '1;
                1:       mask = '0;
                2:       mask = 64'h1;
                3:       mask = 64'h8000_0000_0000_0000;
                4:       mask = {$urandom, $urandom};
                5:       mask = {$urandom, $urandom} & {$urandom, $urandom};
                default: mask = 64'hFFFF_FFFF;
            endcase
            if (phase == 2)
            begin
                mask = '1;
                if (in_d == NEWLINE_BYTE)
                begin
                    in_d = 8'h09;
                end
            end
            write_reg(REG_IN_DELIM, {56'h0, in_d});
            write_reg(REG_OUT_DELIM, {56'h0, out_d});
            write_reg(REG_FIELD_MASK, mask);

            // long hold-off on the output while input keeps coming
            if (phase == 2)
            begin
                hold_req = 1'b1;
            end
            phase_end = rand_items + $urandom_range(40, 70);
            if (phase % 3 == 1)
            begin
                queue_line(1'b1, in_d);
            end
            while (rand_items < phase_end)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    queue_line($urandom_range(0, 30) == 0, in_d);
                end
            end
            phase++;
        end
        drain();

        if (expected_bytes.size() != 0)
        begin
            errors++;
            $display("%0d expected bytes never arrived", expected_bytes.size());
        end
        if (errors == 0)
        begin
            $display("** delimited_field_selector_core: PASSED **");
        end
        else
        begin
            $display("** delimited_field_selector_core: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/dfs_pkg.sv
sv/dfs_front.sv
sv/dfs_queue.sv
sv/dfs_back.sv
sv/delimited_field_selector_core.sv
sim/delimited_field_selector_core_tb.sv
